@@ design/sspp_pkg.sv @@
// ----------------------------------------------------------------------------
// sspp_pkg
// Shared types and constants for the servo status packet parser.
// ----------------------------------------------------------------------------
package sspp_pkg;

   localparam logic [7:0] HEADER_BYTE     = 8'hFF;
   localparam logic [7:0] MIN_LENGTH      = 8'd2;
   localparam logic [8:0] FRAME_OVERHEAD  = 9'd4;

   localparam logic [7:0] MAX_FRAME_RESET = 8'd64;
   localparam logic [7:0] EXP_SIZE_RESET  = 8'd6;

   localparam int CSR_DATA_W = 8;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_MAX_FRAME = 1'b0,
      CSR_EXP_SIZE  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FAULT_NONE     = 3'd0,
      FAULT_HEADER   = 3'd1,
      FAULT_ID       = 3'd2,
      FAULT_LENGTH   = 3'd3,
      FAULT_CHECKSUM = 3'd4,
      FAULT_SIZE     = 3'd5
   } fault_type;

   typedef enum logic [0:0] {
      KIND_PARAM = 1'b0,
      KIND_END   = 1'b1
   } kind_type;

   // one-hot parser phases
   typedef enum logic [6:0] {
      PH_HDR0 = 7'b0000001,
      PH_HDR1 = 7'b0000010,
      PH_ID   = 7'b0000100,
      PH_LEN  = 7'b0001000,
      PH_ERR  = 7'b0010000,
      PH_PAR  = 7'b0100000,
      PH_CHK  = 7'b1000000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] param_byte;
      logic [7:0] servo_id;
      logic [7:0] status_error;
      logic [7:0] param_count;
      fault_type  fault;
      logic       last;
   } rsp_beat_type;

endpackage

@@ design/sspp_channels.sv @@
// ----------------------------------------------------------------------------
// sspp channels
// Valid/ready channel interfaces for received bytes and parser results.
// ----------------------------------------------------------------------------
interface sspp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
   modport mon    (input valid, input rx_byte, input ready);
endinterface

interface sspp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] param_byte;
   logic [7:0] servo_id;
   logic [7:0] status_error;
   logic [7:0] param_count;
   logic [2:0] fault;
   logic       last;

   modport source (output valid, output kind, output param_byte, output servo_id,
                   output status_error, output param_count, output fault,
                   output last, input ready);
   modport sink   (input valid, input kind, input param_byte, input servo_id,
                   input status_error, input param_count, input fault,
                   input last, output ready);
   modport mon    (input valid, input kind, input param_byte, input servo_id,
                   input status_error, input param_count, input fault,
                   input last, input ready);
endinterface

@@ design/servo_status_packet_parser.sv @@
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// Byte-wide parser for half-duplex servo bus status packets: header hunt,
// id/length checks, parameter pass-through and a final verdict beat.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------
//  req_chan  | in  | valid/ready        | rx_byte
//  rsp_chan  | out | valid/ready        | kind, param_byte, servo_id,
//            |     |                    | status_error, param_count, fault, last
//  csr_*     | in  | csr_wr_en only     | csr_index, csr_wr_data
//
//  One byte accepted per cycle while req_chan is ready; its result beat (if any)
//  is registered into the output slot, or into the skid while that slot is held.
//  The parser state update is one pass of logic from the phase/frame
//  registers and the incoming byte.
//  Output register plus a one-beat skid: req_chan stays ready while a result
//  waits; it drops only when both slots hold beats.
//  Synchronous active-high reset: hunting, frame cleared, registers at
//  max_frame_bytes 64 and expected_size 6, both result slots empty.
// ----------------------------------------------------------------------------
module servo_status_packet_parser
   import sspp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sspp_req_if.sink              req_chan,
   sspp_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration
   logic [7:0] max_frame_ff, max_frame_in;
   logic [7:0] exp_size_ff,  exp_size_in;

   // parser state
   phase_type  phase_ff,     phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] sum_ff,       sum_in;
   logic [7:0] id_ff,        id_in;
   logic [7:0] err_ff,       err_in;
   logic [7:0] len_ff,       len_in;
   logic [7:0] params_ff,    params_in;

   // result slots
   logic         out_valid_ff,  out_valid_in;
   rsp_beat_type out_ff,        out_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_beat_type skid_ff,       skid_in;

   logic         accept;
   logic         take;
   logic         res_valid;
   rsp_beat_type res;
   logic [7:0]   b;
   logic [7:0]   rem_dec;
   logic [8:0]   len_total;
   logic [8:0]   frame_total;
   logic         len_ok;
   logic         size_bad;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take           = out_valid_ff && rsp_chan.ready;
   assign b              = req_chan.rx_byte;

   // ---------------------------------------------------------------- csr
   always_comb begin
      max_frame_in = max_frame_ff;
      exp_size_in  = exp_size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_FRAME: max_frame_in = csr_wr_data[7:0];
            CSR_EXP_SIZE:  exp_size_in  = csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- parser
   assign rem_dec     = remaining_ff - 8'd1;
   assign len_total   = {1'b0, b} + FRAME_OVERHEAD;           // no wrap
   assign len_ok      = (b >= MIN_LENGTH) && (len_total <= {1'b0, max_frame_ff});
   assign frame_total = {1'b0, len_ff} + FRAME_OVERHEAD;
   assign size_bad    = (exp_size_ff != 8'd0) && (frame_total != {1'b0, exp_size_ff});

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      id_in        = id_ff;
      err_in       = err_ff;
      len_in       = len_ff;
      params_in    = params_ff;

      res_valid        = 1'b0;
      res.kind         = KIND_END;
      res.param_byte   = 8'd0;
      res.servo_id     = id_ff;
      res.status_error = err_ff;
      res.param_count  = params_ff;
      res.fault        = FAULT_NONE;
      res.last         = 1'b1;

      case (phase_ff)
         PH_HDR0: begin
            if (b == HEADER_BYTE) begin
               remaining_in = 8'd0;
               sum_in       = 8'd0;
               id_in        = 8'd0;
               err_in       = 8'd0;
               len_in       = 8'd0;
               params_in    = 8'd0;
               phase_in     = PH_HDR1;
            end
         end
         PH_HDR1: begin
            if (b == HEADER_BYTE) begin
               phase_in = PH_ID;
            end else begin
               res_valid = 1'b1;
               res.fault = FAULT_HEADER;
               phase_in  = PH_HDR0;   // this byte is not a new first header
            end
         end
         PH_ID: begin
            if (b != HEADER_BYTE) begin
               id_in    = b;
               sum_in   = b;
               phase_in = PH_LEN;
            end else begin
               res_valid = 1'b1;
               res.fault = FAULT_ID;
               phase_in  = PH_HDR0;
            end
         end
         PH_LEN: begin
            if (len_ok) begin
               len_in       = b;
               remaining_in = b;
               sum_in       = sum_ff + b;
               phase_in     = PH_ERR;
            end else begin
               res_valid = 1'b1;
               res.fault = FAULT_LENGTH;
               phase_in  = PH_HDR0;
            end
         end
         PH_ERR: begin
            err_in       = b;
            sum_in       = sum_ff + b;
            remaining_in = rem_dec;
            phase_in     = (rem_dec <= 8'd1) ? PH_CHK : PH_PAR;
         end
         PH_PAR: begin
            sum_in          = sum_ff + b;
            params_in       = params_ff + 8'd1;
            remaining_in    = rem_dec;
            if (rem_dec <= 8'd1) begin
               phase_in = PH_CHK;
            end
            res_valid       = 1'b1;
            res.kind        = KIND_PARAM;
            res.param_byte  = b;
            res.param_count = params_ff + 8'd1;
            res.last        = 1'b0;
         end
         PH_CHK: begin
            // size mismatch outranks a bad checksum
            if (size_bad) begin
               res.fault = FAULT_SIZE;
            end else if (~sum_ff != b) begin
               res.fault = FAULT_CHECKSUM;
            end
            res_valid    = 1'b1;
            remaining_in = 8'd0;
            phase_in     = PH_HDR0;
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
   end

   // ---------------------------------------------------------------- result slots
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && res_valid;
            out_in       = res;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff  <= MAX_FRAME_RESET;
         exp_size_ff   <= EXP_SIZE_RESET;
         phase_ff      <= PH_HDR0;
         remaining_ff  <= 8'd0;
         sum_ff        <= 8'd0;
         id_ff         <= 8'd0;
         err_ff        <= 8'd0;
         len_ff        <= 8'd0;
         params_ff     <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         max_frame_ff  <= max_frame_in;
         exp_size_ff   <= exp_size_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            sum_ff       <= sum_in;
            id_ff        <= id_in;
            err_ff       <= err_in;
            len_ff       <= len_in;
            params_ff    <= params_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_ff.kind;
   assign rsp_chan.param_byte   = out_ff.param_byte;
   assign rsp_chan.servo_id     = out_ff.servo_id;
   assign rsp_chan.status_error = out_ff.status_error;
   assign rsp_chan.param_count  = out_ff.param_count;
   assign rsp_chan.fault        = out_ff.fault;
   assign rsp_chan.last         = out_ff.last;

endmodule

@@ design/sspp_checker.sv @@
// ----------------------------------------------------------------------------
// sspp_checker
// Port-level checks for the servo status packet parser, bound to the top.
// ----------------------------------------------------------------------------
module sspp_checker
   import sspp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_param_byte,
   input logic [7:0] rsp_param_count,
   input logic [2:0] rsp_fault,
   input logic       rsp_last
);

   // a waiting result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_fault) && $stable(rsp_param_byte)
         && $stable(rsp_kind) && $stable(rsp_param_count))
      else $error("rsp beat changed while stalled");

   // both result slots empty out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // parameter beats carry no verdict
   a_param_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PARAM) |->
         (rsp_fault == FAULT_NONE) && !rsp_last)
      else $error("parameter beat with fault or last");

   // every end/fault beat closes the frame
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END) |->
         rsp_last && (rsp_param_byte == 8'd0))
      else $error("end beat without last or with param byte");

   // fault codes stay in range
   a_fault_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fault <= FAULT_SIZE))
      else $error("fault code out of range");

endmodule

bind servo_status_packet_parser sspp_checker u_sspp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_param_byte  (rsp_chan.param_byte),
   .rsp_param_count (rsp_chan.param_count),
   .rsp_fault       (rsp_chan.fault),
   .rsp_last        (rsp_chan.last)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for servo_status_packet_parser. A short directed
// table covers the header hunt, every fault code and the size-over-checksum
// priority. Then randomized status frames run under several csr settings.
// Both channels idle at random, and one stretch holds the result side off.
// ----------------------------------------------------------------------------
module testbench;
   import sspp_pkg::*;

   localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either channel
   localparam int PHASE_BYTES   = 260;   // non-ignored rx bytes per random phase
   localparam int HOLD_CYCLES   = 200;   // long result-side hold-off
   localparam int DRAIN_CYCLES  = 8;     // settle margin after the last owed beat arrives
   localparam int RANDOM_PHASES = 7;

   // one row of the directed table; typed rows carry their verdict beat
   typedef struct {
      logic [7:0]   rx;
      bit           typed;
      rsp_beat_type beat;
   } probe_row_type;

   logic clock;
   logic reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   logic [7:0]    csr_wr_data;

   sspp_req_if req_chan();
   sspp_rsp_if rsp_chan();

   servo_status_packet_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Parser mirror: phase, frame fields and csr copy, updated once per
   // accepted rx beat in acceptance order.
   // ---------------------------------------------------------------------
   phase_type  parse_phase;
   logic [7:0] bytes_left;
   logic [7:0] csum;
   logic [7:0] cur_id;
   logic [7:0] cur_status;
   logic [7:0] cur_length;
   logic [7:0] param_total;
   logic [7:0] cfg_max_frame;
   logic [7:0] cfg_exp_size;

   rsp_beat_type pending_beats[$];  // result beats still owed by the parser
   logic [7:0]   tx_bytes[$];       // rx bytes of the frame being sent
   int           error_count;
   int           useful_bytes;      // rx beats that the hunt does not drop
   bit           req_calm;          // no gaps on the rx side this phase
   bit           rsp_calm;          // no stalls on the result side this phase
   bit           hold_rsp_request;  // ask the receiver for one long hold

   function automatic void clear_frame();
      bytes_left  = '0;
      csum        = '0;
      cur_id      = '0;
      cur_status  = '0;
      cur_length  = '0;
      param_total = '0;
   endfunction

   // Returns 1 when the byte produces a result beat, filled in via beat.
   function automatic bit parse_rx_byte(input logic [7:0] rx, output rsp_beat_type beat);
      bit        emits;
      fault_type verdict_code;
      emits        = 1'b1;
      verdict_code = FAULT_NONE;
      beat         = '0;
      beat.kind    = KIND_END;
      beat.last    = 1'b1;
      case (parse_phase)
         PH_HDR0: begin
            if (rx == HEADER_BYTE) begin
               clear_frame();
               parse_phase = PH_HDR1;
            end
            emits = 1'b0;
         end
         PH_HDR1: begin
            // a bad second header byte gives a header fault, not taken as a new first one
            if (rx == HEADER_BYTE) begin
               parse_phase = PH_ID;
               emits = 1'b0;
            end else begin
               verdict_code = FAULT_HEADER;
               parse_phase  = PH_HDR0;
            end
         end
         PH_ID: begin
            if (rx != HEADER_BYTE) begin
               cur_id      = rx;
               csum        = rx;
               parse_phase = PH_LEN;
               emits       = 1'b0;
            end else begin
               verdict_code = FAULT_ID;
               parse_phase  = PH_HDR0;
            end
         end
         PH_LEN: begin
            // 4 + L formed in 9 bits, so no wrap
            if (rx >= MIN_LENGTH &&
                ({1'b0, rx} + FRAME_OVERHEAD) <= {1'b0, cfg_max_frame}) begin
               cur_length  = rx;
               bytes_left  = rx;
               csum        = csum + rx;
               parse_phase = PH_ERR;
               emits       = 1'b0;
            end else begin
               verdict_code = FAULT_LENGTH;
               parse_phase  = PH_HDR0;
            end
         end
         PH_ERR: begin
            cur_status  = rx;
            csum        = csum + rx;
            bytes_left  = bytes_left - 8'd1;
            parse_phase = (bytes_left <= 8'd1) ? PH_CHK : PH_PAR;
            emits       = 1'b0;
         end
         PH_PAR: begin
            csum        = csum + rx;
            param_total = param_total + 8'd1;
            bytes_left  = bytes_left - 8'd1;
            if (bytes_left <= 8'd1)
               parse_phase = PH_CHK;
            beat.kind       = KIND_PARAM;
            beat.param_byte = rx;
            beat.last       = 1'b0;
         end
         default: begin
            // size mismatch outranks a bad checksum
            if (cfg_exp_size != 8'd0 &&
                ({1'b0, cur_length} + FRAME_OVERHEAD) != {1'b0, cfg_exp_size})
               verdict_code = FAULT_SIZE;
            else if (~csum != rx)
               verdict_code = FAULT_CHECKSUM;
            bytes_left  = '0;
            parse_phase = PH_HDR0;
         end
      endcase
      beat.servo_id     = cur_id;
      beat.status_error = cur_status;
      beat.param_count  = param_total;
      beat.fault        = verdict_code;
      return emits;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table helpers
   // ---------------------------------------------------------------------
   function automatic rsp_beat_type verdict(input logic [7:0] id, input logic [7:0] status,
                                            input logic [7:0] count, input fault_type code);
      rsp_beat_type beat;
      beat              = '0;
      beat.kind         = KIND_END;
      beat.servo_id     = id;
      beat.status_error = status;
      beat.param_count  = count;
      beat.fault        = code;
      beat.last         = 1'b1;
      return beat;
   endfunction

   function automatic probe_row_type plain(input logic [7:0] rx);
      probe_row_type row;
      row.rx    = rx;
      row.typed = 1'b0;
      row.beat  = '0;
      return row;
   endfunction

   function automatic probe_row_type checked(input logic [7:0] rx, input rsp_beat_type beat);
      probe_row_type row;
      row.rx    = rx;
      row.typed = 1'b1;
      row.beat  = beat;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // rx side. Valid only moves at a rising edge and gets one nonblocking
   // assignment per step: low for a gap, or high with the next byte.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] rx, input bit typed, input rsp_beat_type typed_beat);
      int           gap;
      bit           counts;
      bit           has_beat;
      rsp_beat_type beat;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      do @(posedge clock);
      while (!(req_chan.valid === 1'b1 && req_chan.ready === 1'b1));
      // beat accepted at this edge: advance the mirror
      counts   = !(parse_phase == PH_HDR0 && rx != HEADER_BYTE);
      has_beat = parse_rx_byte(rx, beat);
      if (counts)
         useful_bytes++;
      if (typed)
         pending_beats.push_back(typed_beat);
      else if (has_beat)
         pending_beats.push_back(beat);
   endtask

   // Queue one randomized item: mostly well-formed frames, some noise,
   // broken headers, 0xFF ids, out-of-range lengths and bad checksums.
   task automatic queue_frame();
      int         pick;
      int         lane;
      int         max_len;
      int         len;
      int         cap;
      logic [7:0] id;
      logic [7:0] status;
      logic [7:0] sum;
      logic [7:0] val;
      pick    = $urandom_range(0, 99);
      max_len = int'(cfg_max_frame) - 4;
      if (pick < 8) begin
         repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
         return;
      end
      tx_bytes.push_back(HEADER_BYTE);
      if (pick < 12) begin
         tx_bytes.push_back(8'($urandom_range(0, 254)));
         return;
      end
      tx_bytes.push_back(HEADER_BYTE);
      id = (pick < 15) ? HEADER_BYTE : 8'($urandom_range(0, 254));
      tx_bytes.push_back(id);
      if (id == HEADER_BYTE)
         return;
      lane = $urandom_range(0, 99);
      cap  = (max_len < 14) ? ((max_len < 2) ? 2 : max_len) : 14;
      if (lane < 8) begin
         if (max_len < 2 || $urandom_range(0, 1) == 0)
            len = $urandom_range(0, 1);
         else
            len = $urandom_range(max_len + 1, 255);
      end else if (cfg_exp_size >= 8'd6 && lane < 50 && (cfg_exp_size <= 8'd20 || lane < 12)) begin
         len = int'(cfg_exp_size) - 4;
      end else if (lane < 95 || max_len <= 14) begin
         len = $urandom_range(2, cap);
      end else begin
         // rare long frame
         len = $urandom_range(15, max_len);
      end
      tx_bytes.push_back(8'(len));
      if (len < 2 || len > max_len)
         return;
      status = 8'($urandom);
      sum    = id + 8'(len) + status;
      tx_bytes.push_back(status);
      repeat (len - 2) begin
         val = 8'($urandom);
         sum = sum + val;
         tx_bytes.push_back(val);
      end
      if ($urandom_range(0, 99) < 85)
         tx_bytes.push_back(~sum);
      else
         tx_bytes.push_back(8'($urandom));
   endtask

   // Drop valid, let every owed beat arrive, then wait out the pipeline.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] max_frame, input logic [7:0] exp_size);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_MAX_FRAME;
      csr_wr_data <= max_frame;
      @(posedge clock);
      csr_index   <= CSR_EXP_SIZE;
      csr_wr_data <= exp_size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_max_frame = max_frame;
      cfg_exp_size  = exp_size;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus: reset, directed table at reset csr values, then random
   // phases, each under its own csr setting.
   // ---------------------------------------------------------------------
   initial begin
      probe_row_type directed_rows[29];
      logic [7:0]    max_tab[RANDOM_PHASES];
      logic [7:0]    exp_tab[RANDOM_PHASES];

      reset            = 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_MAX_FRAME;
      csr_wr_data      <= 8'h00;
      error_count      = 0;
      useful_bytes     = 0;
      req_calm         = 1'b0;
      rsp_calm         = 1'b0;
      hold_rsp_request = 1'b0;
      parse_phase      = PH_HDR0;
      clear_frame();
      cfg_max_frame    = MAX_FRAME_RESET;
      cfg_exp_size     = EXP_SIZE_RESET;

      directed_rows = '{
         plain(8'h12),                                         // dropped while hunting
         plain(8'hFF),
         checked(8'h00, verdict(8'h00, 8'h00, 8'h00, FAULT_HEADER)),
         plain(8'hFF), plain(8'hFF),
         checked(8'hFF, verdict(8'h00, 8'h00, 8'h00, FAULT_ID)),
         plain(8'hFF), plain(8'hFF), plain(8'h01),
         checked(8'h01, verdict(8'h01, 8'h00, 8'h00, FAULT_LENGTH)),
         // shortest good frame, top id: sum FE+02+80 = 80, checksum 7F
         plain(8'hFF), plain(8'hFF), plain(8'hFE), plain(8'h02), plain(8'h80),
         checked(8'h7F, verdict(8'hFE, 8'h80, 8'h00, FAULT_NONE)),
         // bad checksum, size right
         plain(8'hFF), plain(8'hFF), plain(8'h05), plain(8'h02), plain(8'h00),
         checked(8'h00, verdict(8'h05, 8'h00, 8'h00, FAULT_CHECKSUM)),
         // one param, size 7 vs 6 and a bad checksum: size wins
         plain(8'hFF), plain(8'hFF), plain(8'h00), plain(8'h03), plain(8'hFF),
         plain(8'h55),
         checked(8'h00, verdict(8'h00, 8'hFF, 8'h01, FAULT_SIZE))
      };

      max_tab = '{8'd255, 8'd6, 8'd64, 8'd255, 8'($urandom_range(6, 255)), 8'd20, 8'd6};
      exp_tab = '{8'd0, 8'd6, 8'd0, 8'd255, 8'($urandom), 8'd14, 8'd0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].beat);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         set_config(max_tab[p], exp_tab[p]);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if (p == 0) begin
            // flood the rx side while results are held off
            req_calm         = 1'b1;
            hold_rsp_request = 1'b1;
         end
         useful_bytes = 0;
         while (useful_bytes < PHASE_BYTES) begin
            if (tx_bytes.size() == 0)
               queue_frame();
            send_byte(tx_bytes.pop_front(), 1'b0, '0);
         end
         while (tx_bytes.size() != 0)
            send_byte(tx_bytes.pop_front(), 1'b0, '0);
         // close any frame left open by noise so csr writes land on a hunting parser
         while (parse_phase != PH_HDR0)
            send_byte(8'h00, 1'b0, '0);
      end

      settle();
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random stalls, one long hold on request, and the check
   // of every accepted beat against the oldest owed beat.
   // ---------------------------------------------------------------------
   task automatic compare_beat(input rsp_beat_type want, input rsp_beat_type got);
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, actual %0d", want.kind, got.kind);
         error_count++;
      end
      if (got.param_byte !== want.param_byte) begin
         $error("param_byte: expected %0h, actual %0h", want.param_byte, got.param_byte);
         error_count++;
      end
      if (got.servo_id !== want.servo_id) begin
         $error("servo_id: expected %0h, actual %0h", want.servo_id, got.servo_id);
         error_count++;
      end
      if (got.status_error !== want.status_error) begin
         $error("status_error: expected %0h, actual %0h", want.status_error, got.status_error);
         error_count++;
      end
      if (got.param_count !== want.param_count) begin
         $error("param_count: expected %0d, actual %0d", want.param_count, got.param_count);
         error_count++;
      end
      if (got.fault !== want.fault) begin
         $error("fault: expected %0d, actual %0d", want.fault, got.fault);
         error_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         error_count++;
      end
   endtask

   initial begin
      int           stall;
      rsp_beat_type got;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            stall            = HOLD_CYCLES;
            hold_rsp_request = 1'b0;
         end else begin
            stall = rsp_calm ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock);
         while (reset !== 1'b0 || !(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
         got.kind         = kind_type'(rsp_chan.kind);
         got.param_byte   = rsp_chan.param_byte;
         got.servo_id     = rsp_chan.servo_id;
         got.status_error = rsp_chan.status_error;
         got.param_count  = rsp_chan.param_count;
         got.fault        = fault_type'(rsp_chan.fault);
         got.last         = rsp_chan.last;
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d fault %0d", got.kind, got.fault);
            error_count++;
         end else begin
            compare_beat(pending_beats.pop_front(), got);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without a beat on either channel ends the run.
   // ---------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench: done, errors");
      $finish;
   end

endmodule
